FILE: rtl/aseuler_pkg.sv
package aseuler_pkg;

    localparam int W = 32;
    localparam int F = 16;
    localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] ONEV = 32'h0001_0000;
    localparam logic [W-1:0] LN2 = 32'h0000_B172;
    // floor(2^32 / LN2), quotient estimate is low by at most one
    localparam logic [16:0] LN2_RECIP = 17'd94548;

    localparam logic [2:0] REG_STEP_COUNT   = 3'd0;
    localparam logic [2:0] REG_TIME_STEP    = 3'd1;
    localparam logic [2:0] REG_MAX_SIZE     = 3'd2;
    localparam logic [2:0] REG_MIN_SIZE     = 3'd3;
    localparam logic [2:0] REG_GROWTH_GAIN  = 3'd4;
    localparam logic [2:0] REG_FORCE_SCALE  = 3'd5;
    localparam logic [2:0] REG_SLIP_OFFSET  = 3'd6;
    localparam logic [2:0] REG_CATCH_OFFSET = 3'd7;

    typedef enum logic [4:0] {
        S_IDLE, S_STEP, S_DIV, S_DIVW, S_PHI, S_GROW,
        S_EXP1, S_EXP1W, S_EXP2, S_EXP2W, S_RATE, S_DECAY, S_DIFF, S_DT, S_UPD, S_DONE
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_DIV, OP_PHI, OP_GROW, OP_EXP1, OP_EXP2,
        OP_RATE, OP_DECAY, OP_DIFF, OP_DT, OP_UPD
    } op_t;

    typedef struct packed {
        op_t  op;
        logic unit_start;
    } cmd_t;

    typedef struct packed {
        logic unit_done;
    } sts_t;

    function automatic logic [W-1:0] sat_add(input logic [W-1:0] a, input logic [W-1:0] b);
        logic [W:0] s;
        s = {a[W-1], a} + {b[W-1], b};
        if (s[W] != s[W-1]) return s[W] ? MINV : MAXV;
        return s[W-1:0];
    endfunction

    function automatic logic [W-1:0] sat_sub(input logic [W-1:0] a, input logic [W-1:0] b);
        logic [W:0] s;
        s = {a[W-1], a} - {b[W-1], b};
        if (s[W] != s[W-1]) return s[W] ? MINV : MAXV;
        return s[W-1:0];
    endfunction

    function automatic logic [W-1:0] mag_of(input logic [W-1:0] a);
        return a[W-1] ? (~a + 1'b1) : a;
    endfunction

    function automatic logic [W-1:0] sat_mag(input logic neg, input logic [2*W-1:0] m);
        if (neg) begin
            if (m > {{W{1'b0}}, MINV}) return MINV;
            return ~m[W-1:0] + 1'b1;
        end
        if (m > {{W{1'b0}}, MAXV}) return MAXV;
        return m[W-1:0];
    endfunction

    function automatic logic [W-1:0] sat_mul(input logic [W-1:0] a, input logic [W-1:0] b);
        logic [2*W-1:0] p;
        p = (mag_of(a) * mag_of(b)) >> F;
        return sat_mag(a[W-1] ^ b[W-1], p);
    endfunction

endpackage

FILE: rtl/aseuler_div.sv
module aseuler_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] num,
    input  logic [31:0] den,
    output logic        done,
    output logic [31:0] quot
);
    import aseuler_pkg::*;

    logic [6:0]     cnt_reg, cnt_next;
    logic           act_reg, act_next;
    logic [W+F-1:0] n_reg, n_next;
    logic [W:0]     rem_reg, rem_next;
    logic [W+F-1:0] q_reg, q_next;
    logic [W-1:0]   d_reg, d_next;
    logic           neg_reg, neg_next, z_reg, z_next;
    logic [W:0]     sh;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            act_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            act_reg <= act_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk) begin
        n_reg <= n_next; rem_reg <= rem_next; q_reg <= q_next;
        d_reg <= d_next; neg_reg <= neg_next; z_reg <= z_next;
    end

    always_comb begin
        act_next = act_reg; cnt_next = cnt_reg;
        n_next = n_reg; rem_next = rem_reg; q_next = q_reg;
        d_next = d_reg; neg_next = neg_reg; z_next = z_reg;
        done = 1'b0;
        sh = {rem_reg[W-1:0], n_reg[W+F-1]};
        if (start) begin
            act_next = 1'b1;
            cnt_next = 7'(W + F);
            n_next = {mag_of(num), {F{1'b0}}};
            rem_next = '0; q_next = '0;
            d_next = mag_of(den);
            neg_next = num[W-1] ^ den[W-1];
            z_next = (den == '0);
        end else if (act_reg) begin
            if (cnt_reg == '0) begin
                act_next = 1'b0;
                done = 1'b1;
            end else begin
                n_next = n_reg << 1;
                if (sh >= {1'b0, d_reg}) begin
                    rem_next = sh - {1'b0, d_reg};
                    q_next = {q_reg[W+F-2:0], 1'b1};
                end else begin
                    rem_next = sh;
                    q_next = {q_reg[W+F-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 7'd1;
            end
        end
    end

    always_comb begin
        if (z_reg) quot = neg_reg ? MINV : MAXV;
        else quot = sat_mag(neg_reg, {{(W-F){1'b0}}, q_reg});
    end
endmodule

FILE: rtl/aseuler_exp.sv
module aseuler_exp (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] x,
    output logic        done,
    output logic [31:0] y
);
    import aseuler_pkg::*;

    typedef enum logic [2:0] {E_IDLE, E_SPLIT, E_FIX, E_MUL, E_DIV, E_ACC, E_SHIFT} est_t;

    est_t         st_reg, st_next;
    logic [W-1:0] x_reg, x_next;
    logic [W-1:0] k_reg, k_next;
    logic [W-1:0] r_reg, r_next;
    logic [W-1:0] sum_reg, sum_next;
    logic [W-1:0] term_reg, term_next;
    logic [5:0]   n_reg, n_next;
    logic [W-1:0] y_reg, y_next;
    logic [15:0]  kq_reg, kq_next;
    logic [5:0]   dr_reg, dr_next;
    logic [5:0]   dc_reg, dc_next;
    logic [W-1:0] mag_x, kl, kd, kq, kr;
    logic [47:0]  kprod;
    logic [6:0]   dsh;
    logic [W:0]   lim;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) st_reg <= E_IDLE;
        else st_reg <= st_next;
    end

    always_ff @(posedge clk) begin
        x_reg <= x_next; k_reg <= k_next; r_reg <= r_next; sum_reg <= sum_next;
        term_reg <= term_next; n_reg <= n_next; y_reg <= y_next;
        kq_reg <= kq_next; dr_reg <= dr_next; dc_reg <= dc_next;
    end

    assign mag_x = mag_of(x_reg);
    assign kprod = {16'b0, mag_x} * {31'b0, LN2_RECIP};
    assign kl = {16'b0, kq_reg} * LN2;
    assign kd = mag_x - kl;
    assign kq = (kd >= LN2) ? {16'b0, kq_reg} + 32'd1 : {16'b0, kq_reg};
    assign kr = (kd >= LN2) ? kd - LN2 : kd;
    assign dsh = {dr_reg, term_reg[W-1]};
    assign y = y_next;

    always_comb begin
        st_next = st_reg;
        x_next = x_reg; k_next = k_reg; r_next = r_reg; sum_next = sum_reg;
        term_next = term_reg; n_next = n_reg; y_next = y_reg;
        kq_next = kq_reg; dr_next = dr_reg; dc_next = dc_reg;
        done = 1'b0;
        lim = '0;
        unique case (st_reg)
            E_IDLE: if (start)
            begin
                x_next = x;
                st_next = E_SPLIT;
            end
            E_SPLIT:
            begin
                kq_next = kprod[47:32];
                st_next = E_FIX;
            end
            E_FIX:
            begin
                if (!x_reg[W-1]) begin
                    k_next = kq; r_next = kr;
                end else if (kr == '0) begin
                    k_next = ~kq + 1'b1; r_next = '0;
                end else begin
                    k_next = ~kq; r_next = LN2 - kr;
                end
                sum_next = ONEV; term_next = ONEV; n_next = 6'd1;
                st_next = E_MUL;
            end
            E_MUL:
            begin
                term_next = sat_mul(term_reg, r_reg);
                dr_next = '0;
                dc_next = 6'd32;
                st_next = E_DIV;
            end
            E_DIV:
            begin
                if (dsh >= {1'b0, n_reg}) begin
                    dr_next = 6'(dsh - {1'b0, n_reg});
                    term_next = {term_reg[W-2:0], 1'b1};
                end else begin
                    dr_next = dsh[5:0];
                    term_next = {term_reg[W-2:0], 1'b0};
                end
                dc_next = dc_reg - 6'd1;
                if (dc_reg == 6'd1) st_next = E_ACC;
            end
            E_ACC:
            begin
                if (term_reg == '0 || n_reg == 6'd48) begin
                    if (term_reg != '0) sum_next = sat_add(sum_reg, term_reg);
                    st_next = E_SHIFT;
                end else begin
                    sum_next = sat_add(sum_reg, term_reg);
                    n_next = n_reg + 6'd1;
                    st_next = E_MUL;
                end
            end
            E_SHIFT:
            begin
                if (!k_reg[W-1]) begin
                    lim = {1'b0, MAXV} >> k_reg;
                    if (k_reg >= 32'd63 || {1'b0, sum_reg} > lim) y_next = MAXV;
                    else y_next = sum_reg << k_reg;
                end else if ($signed(k_reg) <= -32'sd64) begin
                    y_next = '0;
                end else begin
                    y_next = sum_reg >> (~k_reg + 1'b1);
                end
                done = 1'b1;
                st_next = E_IDLE;
            end
            default: st_next = E_IDLE;
        endcase
    end
endmodule

FILE: rtl/aseuler_dp.sv
module aseuler_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  aseuler_pkg::cmd_t   cmd,
    output aseuler_pkg::sts_t   sts,
    input  logic [31:0]         force_in,
    input  logic [30:0]         start_size,
    input  logic [30:0]         time_step,
    input  logic [30:0]         max_size,
    input  logic [30:0]         min_size,
    input  logic [30:0]         growth_gain,
    input  logic [31:0]         force_scale,
    input  logic [31:0]         slip_offset,
    input  logic [31:0]         catch_offset,
    output logic [30:0]         final_size
);
    import aseuler_pkg::*;

    logic [W-1:0] size_reg, size_next, f_reg, f_next;
    logic [W-1:0] phi_reg, phi_next, g_reg, g_next, e1_reg, e1_next, a_reg, a_next;
    logic [W-1:0] dq, ey, nt, n0, upd, ex_in;
    logic         div_done, exp_done, div_go, exp_go;

    assign nt = {1'b0, max_size};
    assign n0 = {1'b0, min_size};
    assign div_go = cmd.unit_start && cmd.op == OP_DIV;
    assign exp_go = cmd.unit_start && (cmd.op == OP_EXP1 || cmd.op == OP_EXP2);
    assign ex_in = (cmd.op == OP_EXP1) ? sat_sub(phi_reg, slip_offset)
                                       : sat_sub(catch_offset, phi_reg);
    assign sts.unit_done = div_done | exp_done;
    assign upd = sat_add(size_reg, a_reg);
    assign final_size = size_reg[30:0];

    aseuler_div u_div (.clk(clk), .rst_n(rst_n), .start(div_go), .num(f_reg),
                       .den(size_reg), .done(div_done), .quot(dq));
    aseuler_exp u_exp (.clk(clk), .rst_n(rst_n), .start(exp_go), .x(ex_in),
                       .done(exp_done), .y(ey));

    always_ff @(posedge clk) begin
        size_reg <= size_next; f_reg <= f_next; phi_reg <= phi_next;
        g_reg <= g_next; e1_reg <= e1_next; a_reg <= a_next;
    end

    always_comb begin
        size_next = size_reg; f_next = f_reg; phi_next = phi_reg;
        g_next = g_reg; e1_next = e1_reg; a_next = a_reg;
        unique case (cmd.op)
            OP_LOAD:
            begin
                f_next = force_in;
                size_next = {1'b0, start_size};
            end
            OP_DIV: if (div_done) phi_next = dq;
            OP_PHI:   phi_next = sat_mul(force_scale, phi_reg);
            OP_GROW:  g_next = sat_mul({1'b0, growth_gain}, sat_sub(nt, size_reg));
            OP_EXP1: if (exp_done) e1_next = ey;
            OP_EXP2: if (exp_done) a_next = sat_add(e1_reg, ey);
            OP_DECAY: a_next = sat_mul(size_reg, a_reg);
            OP_DIFF:  a_next = sat_sub(g_reg, a_reg);
            OP_DT:    a_next = sat_mul({1'b0, time_step}, a_reg);
            OP_UPD:
            begin
                if ($signed(upd) > $signed(nt)) size_next = nt;
                else if ($signed(upd) < $signed(n0)) size_next = n0;
                else size_next = upd;
            end
            default: ;
        endcase
    end
endmodule

FILE: rtl/aseuler_ctrl.sv
module aseuler_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [15:0]         step_count,
    input  aseuler_pkg::sts_t   sts,
    output aseuler_pkg::cmd_t   cmd,
    output logic                busy,
    output logic                done
);
    import aseuler_pkg::*;

    state_t      st_reg, st_next;
    logic [15:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            st_reg <= S_IDLE;
            cnt_reg <= '0;
        end else begin
            st_reg <= st_next;
            cnt_reg <= cnt_next;
        end
    end

    always_comb begin
        st_next = st_reg; cnt_next = cnt_reg;
        cmd.op = OP_NONE; cmd.unit_start = 1'b0;
        busy = (st_reg != S_IDLE);
        done = 1'b0;
        unique case (st_reg)
            S_IDLE: if (start)
            begin
                cmd.op = OP_LOAD;
                cnt_next = step_count;
                st_next = S_STEP;
            end
            S_STEP: st_next = (cnt_reg == '0) ? S_DONE : S_DIV;
            S_DIV:
            begin
                cmd.op = OP_DIV; cmd.unit_start = 1'b1; st_next = S_DIVW;
            end
            S_DIVW:
            begin
                cmd.op = OP_DIV;
                if (sts.unit_done) st_next = S_PHI;
            end
            S_PHI:  begin cmd.op = OP_PHI; st_next = S_GROW; end
            S_GROW: begin cmd.op = OP_GROW; st_next = S_EXP1; end
            S_EXP1:
            begin
                cmd.op = OP_EXP1; cmd.unit_start = 1'b1; st_next = S_EXP1W;
            end
            S_EXP1W:
            begin
                cmd.op = OP_EXP1;
                if (sts.unit_done) st_next = S_EXP2;
            end
            S_EXP2:
            begin
                cmd.op = OP_EXP2; cmd.unit_start = 1'b1; st_next = S_EXP2W;
            end
            S_EXP2W:
            begin
                cmd.op = OP_EXP2;
                if (sts.unit_done) st_next = S_DECAY;
            end
            S_RATE: st_next = S_DECAY;
            S_DECAY: begin cmd.op = OP_DECAY; st_next = S_DIFF; end
            S_DIFF:  begin cmd.op = OP_DIFF; st_next = S_DT; end
            S_DT:    begin cmd.op = OP_DT; st_next = S_UPD; end
            S_UPD:
            begin
                cmd.op = OP_UPD;
                cnt_next = cnt_reg - 16'd1;
                st_next = S_STEP;
            end
            S_DONE:
            begin
                done = 1'b1;
                st_next = S_IDLE;
            end
            default: st_next = S_IDLE;
        endcase
    end

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> st_reg == S_IDLE) else $error("done not followed by idle");
    a_start_load: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> st_reg == S_STEP) else $error("start not taken");
    a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (busy && st_reg != S_UPD) |=> $stable(cnt_reg)) else $error("count moved");
endmodule

FILE: rtl/adhesion_size_euler_integrator_core.sv
// channel | signals                                       | handshake
// cfg     | cfg_valid cfg_ready cfg_index cfg_data       | valid & ready
// in      | start busy force_in start_size                | start & !busy
// out     | done final_size                               | done strobe, one cycle
// Each Euler step runs a 48-bit restoring divider and two exps; an exp computes a
// Taylor series with one multiply and one bit-serial divide per term, up to 48 terms,
// then scales the sum by a power of two. done comes after step_count steps from start.
// Reset clears the controller and loads register defaults.
// The receiver cannot stall; cfg_ready is always high; busy holds start off per item.
module adhesion_size_euler_integrator_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] force_in,
    input  logic [30:0] start_size,
    output logic        done,
    output logic [30:0] final_size
);
    import aseuler_pkg::*;

    logic [15:0] step_count_reg;
    logic [30:0] time_step_reg, max_size_reg, min_size_reg, growth_gain_reg;
    logic [31:0] force_scale_reg, slip_offset_reg, catch_offset_reg;
    cmd_t        cmd;
    sts_t        sts;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            step_count_reg <= 16'd1;
            time_step_reg <= 31'd6554;
            max_size_reg <= 31'd6553600;
            min_size_reg <= 31'd65536;
            growth_gain_reg <= 31'd65536;
            force_scale_reg <= 32'd65536;
            slip_offset_reg <= '0;
            catch_offset_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_STEP_COUNT:   step_count_reg <= cfg_data[15:0];
                REG_TIME_STEP:    time_step_reg <= cfg_data[30:0];
                REG_MAX_SIZE:     max_size_reg <= cfg_data[30:0];
                REG_MIN_SIZE:     min_size_reg <= cfg_data[30:0];
                REG_GROWTH_GAIN:  growth_gain_reg <= cfg_data[30:0];
                REG_FORCE_SCALE:  force_scale_reg <= cfg_data;
                REG_SLIP_OFFSET:  slip_offset_reg <= cfg_data;
                REG_CATCH_OFFSET: catch_offset_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    aseuler_ctrl u_ctrl (.clk(clk), .rst_n(rst_n), .start(start),
        .step_count(step_count_reg), .sts(sts), .cmd(cmd), .busy(busy), .done(done));

    aseuler_dp u_dp (.clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .force_in(force_in), .start_size(start_size), .time_step(time_step_reg),
        .max_size(max_size_reg), .min_size(min_size_reg),
        .growth_gain(growth_gain_reg), .force_scale(force_scale_reg),
        .slip_offset(slip_offset_reg), .catch_offset(catch_offset_reg),
        .final_size(final_size));
endmodule

FILE: sim/tb_adhesion_size_euler_integrator_core.sv
module tb_adhesion_size_euler_integrator_core;
    timeunit 1ns;
    timeprecision 1ps;
    import aseuler_pkg::*;

    localparam longint QMAX = 64'sd2147483647;
    localparam longint QMIN = -64'sd2147483648;
    localparam longint LN2_Q = 64'sd45426;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = REG_STEP_COUNT;
    logic [31:0] cfg_data = '0;
    logic        start = 1'b0;
    logic        busy;
    logic [31:0] force_in = '0;
    logic [30:0] start_size = '0;
    logic        done;
    logic [30:0] final_size;

    // predictor copy of the registers
    longint unsigned steps_q;
    longint dt_q, nt_q, n0_q, gain_q, fscale_q, slip_q, catch_q;

    logic [30:0] size_fifo[$];
    int          mismatches = 0;
    bit          no_idle = 1'b0;

    typedef struct {
        int          steps;
        logic [31:0] frc;
        logic [30:0] sz;
        bit          typed;
        logic [30:0] want;
    } vec_t;

    vec_t vecs[] = '{
        '{0,     32'h7FFF_FFFF, 31'h7FFF_FFFF, 1, 31'h7FFF_FFFF},
        '{0,     32'h8000_0000, 31'h0,         1, 31'h0},
        '{0,     32'h0000_04D2, 31'h0001_0000, 1, 31'h0001_0000},
        '{1,     32'h0,         31'h0,         0, 31'h0},
        '{1,     32'h8000_0000, 31'h0,         0, 31'h0},
        '{1,     32'h7FFF_FFFF, 31'h0,         0, 31'h0},
        '{1,     32'h0001_0000, 31'h0001_0000, 0, 31'h0},
        '{1,     32'h7FFF_FFFF, 31'h7FFF_FFFF, 0, 31'h0},
        '{1,     32'h8000_0000, 31'h7FFF_FFFF, 0, 31'h0},
        '{1,     32'hFFFF_FFFF, 31'h0064_0000, 0, 31'h0},
        '{3,     32'h0002_0000, 31'h0005_0000, 0, 31'h0},
        '{2,     32'hFFF0_0000, 31'h0064_0000, 0, 31'h0},
        '{5,     32'h0040_0000, 31'h0000_0001, 0, 31'h0},
        '{300,   32'h0000_8000, 31'h0003_0000, 0, 31'h0}
    };

    adhesion_size_euler_integrator_core dut (.*);

    always #5 clk = ~clk;

    function automatic longint q_from_mag(bit neg, longint unsigned m);
        if (neg) return (m >= 64'd2147483648) ? QMIN : -longint'(m);
        return (m > 64'd2147483647) ? QMAX : longint'(m);
    endfunction

    function automatic longint q_add(longint a, longint b);
        return (a + b > QMAX) ? QMAX : (a + b < QMIN) ? QMIN : a + b;
    endfunction

    function automatic longint q_sub(longint a, longint b);
        return (a - b > QMAX) ? QMAX : (a - b < QMIN) ? QMIN : a - b;
    endfunction

    function automatic longint q_mul(longint a, longint b);
        longint unsigned ua, ub;
        ua = (a < 0) ? -a : a;
        ub = (b < 0) ? -b : b;
        return q_from_mag((a < 0) != (b < 0), (ua * ub) >> 16);
    endfunction

    function automatic longint q_div(longint a, longint b);
        longint unsigned ua, ub;
        ua = (a < 0) ? -a : a;
        ub = (b < 0) ? -b : b;
        if (b == 0) return (a < 0) ? QMIN : QMAX;
        return q_from_mag((a < 0) != (b < 0), (ua << 16) / ub);
    endfunction

    function automatic longint q_exp(longint x);
        longint k, r, sum, term;
        k = x / LN2_Q;
        r = x % LN2_Q;
        if (r < 0) begin
            r += LN2_Q;
            k--;
        end
        sum = 64'sd65536;
        term = 64'sd65536;
        for (int n = 1; n <= 48; n++) begin
            term = q_mul(term, r) / n;
            if (term == 0) break;
            sum = q_add(sum, term);
        end
        if (k >= 0) begin
            if (k >= 63 || sum > (QMAX >>> k)) return QMAX;
            return sum << k;
        end
        if (k <= -64) return 0;
        return sum >>> (-k);
    endfunction

    function automatic logic [30:0] adhesion_after_steps(logic [31:0] frc, logic [30:0] sz);
        longint f, n, phi, growth, rate, decay;
        f = longint'(signed'(frc));
        n = longint'({1'b0, sz});
        for (longint unsigned i = 0; i < steps_q; i++) begin
            phi = q_mul(fscale_q, q_div(f, n));
            growth = q_mul(gain_q, q_sub(nt_q, n));
            rate = q_add(q_exp(q_sub(phi, slip_q)), q_exp(q_sub(catch_q, phi)));
            decay = q_mul(n, rate);
            n = q_add(n, q_mul(dt_q, q_sub(growth, decay)));
            if (n > nt_q) n = nt_q;
            else if (n < n0_q) n = n0_q;
        end
        return n[30:0];
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_STEP_COUNT:   steps_q  = val[15:0];
            REG_TIME_STEP:    dt_q     = val[30:0];
            REG_MAX_SIZE:     nt_q     = val[30:0];
            REG_MIN_SIZE:     n0_q     = val[30:0];
            REG_GROWTH_GAIN:  gain_q   = val[30:0];
            REG_FORCE_SCALE:  fscale_q = longint'(signed'(val));
            REG_SLIP_OFFSET:  slip_q   = longint'(signed'(val));
            REG_CATCH_OFFSET: catch_q  = longint'(signed'(val));
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (size_fifo.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic send_size_word(logic [31:0] frc, logic [30:0] sz, bit typed,
                                  logic [30:0] want);
        if (!no_idle && $urandom_range(99) < 22) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        start      <= 1'b1;
        force_in   <= frc;
        start_size <= sz;
        @(negedge clk);
        while (busy) @(negedge clk);
        @(posedge clk);
        size_fifo.push_back(typed ? want : adhesion_after_steps(frc, sz));
    endtask

    task automatic load_phase(int p);
        logic [31:0] v[8];
        case (p)
            0: v = '{32'd1, 32'h0, 32'h0, 32'h0, 32'h0,
                     32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
            1: v = '{32'd4, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                     32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
            2: v = '{32'd3, 32'd6554, 32'h0010_0000, 32'h0050_0000, 32'h0001_0000,
                     32'h0001_0000, 32'h0, 32'h0};
            default: begin
                v[0] = $urandom_range(1, 6);
                v[1] = $urandom_range(0, 32'h0000_8000);
                v[2] = $urandom_range(32'h0001_0000, 32'h00C8_0000);
                v[3] = $urandom_range(0, 32'h0002_0000);
                v[4] = $urandom_range(0, 32'h0002_0000);
                v[5] = ($urandom_range(3) == 0) ? $urandom
                       : 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
                v[6] = ($urandom_range(3) == 0) ? $urandom
                       : 32'($signed($urandom_range(0, 32'h000A_0000)) - 32'sh0005_0000);
                v[7] = ($urandom_range(3) == 0) ? $urandom
                       : 32'($signed($urandom_range(0, 32'h000A_0000)) - 32'sh0005_0000);
            end
        endcase
        for (int i = 0; i < 8; i++) write_reg(3'(i), v[i]);
        cfg_valid <= 1'b0;
    endtask

    always @(negedge clk) begin
        if (rst_n && done) begin
            if (size_fifo.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word: final_size=%h", final_size);
            end else begin
                logic [30:0] exp_size;
                exp_size = size_fifo.pop_front();
                if (final_size !== exp_size) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("final_size mismatch: exp %h got %h", exp_size, final_size);
                end
            end
        end
    end

    initial begin
        steps_q = 1; dt_q = 6554; nt_q = 6553600; n0_q = 65536; gain_q = 65536;
        fscale_q = 65536; slip_q = 0; catch_q = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (vecs[i]) begin
            if (longint'(vecs[i].steps) != steps_q) begin
                wait_drained();
                write_reg(REG_STEP_COUNT, 32'(vecs[i].steps));
                cfg_valid <= 1'b0;
            end
            send_size_word(vecs[i].frc, vecs[i].sz, vecs[i].typed, vecs[i].want);
        end

        for (int p = 0; p < 7; p++) begin
            wait_drained();
            load_phase(p);
            no_idle = (p == 3);
            for (int j = 0; j < 20; j++) begin
                logic [31:0] frc;
                logic [30:0] sz;
                frc = ($urandom_range(2) == 0) ? $urandom
                      : 32'($signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000);
                case ($urandom_range(5))
                    0: sz = 31'($urandom);
                    1: sz = 31'($urandom_range(0, 3));
                    default: sz = 31'(nt_q > 0 ? $urandom_range(0, 32'(nt_q)) : 0);
                endcase
                send_size_word(frc, sz, 1'b0, 31'h0);
            end
        end

        wait_drained();
        repeat (300) @(posedge clk);
        if (mismatches == 0 && size_fifo.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #30ms;
        $display("DONE: errors detected");
        $finish;
    end
endmodule
